// ===== sv/smbpg_pkg.sv =====
// shared types, constants and the pan sine table function for the stereo mix bus
package smbpg_pkg;

    localparam int MAX_FRAMES     = 1024;
    localparam int PAN_TABLE_SIZE = 256;
    localparam int ACC_BITS       = 24;

    localparam int SLOT_W     = 10;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int IDX_W      = $clog2(PAN_TABLE_SIZE + 1);
    localparam int PAN_SHIFT  = $clog2(PAN_TABLE_SIZE);
    localparam int GAIN_W     = 17;
    localparam int CONTRIB_W  = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // power of two, pointers wrap naturally
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEREO_OUTPUT = 1'b0,
        CFG_SOLO_ACTIVE   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        [SLOT_W-1:0] frame_slot;
        logic signed [15:0]       sample_left;
        logic signed [15:0]       sample_right;
        logic        [15:0]       clip_gain;
        logic        [15:0]       track_gain;
        logic        [14:0]       fade_gain;
        logic signed [15:0]       clip_pan;
        logic signed [15:0]       trk_pan;
        logic                     clip_muted;
        logic                     trk_muted;
        logic                     trk_solo;
        logic                     last_contribution;
    } t_mix_item;

    typedef struct packed {
        logic        [SLOT_W-1:0] out_slot;
        logic signed [15:0]       out_left;
        logic signed [15:0]       out_right;
        logic                     saturated;
    } t_frame_item;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] left;
        logic signed [ACC_BITS-1:0] right;
    } t_acc_pair;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_rd_req;

    typedef struct packed {
        logic                        valid;
        logic [SLOT_W-1:0]           slot;
        logic                        last;
        logic signed [CONTRIB_W-1:0] contrib_l;
        logic signed [CONTRIB_W-1:0] contrib_r;
    } t_acc_req;

    // term times x squared, back in Q30
    function automatic longint taylor_step(longint term, longint x);
        return (((term * x) >>> 30) * x) >>> 30;
    endfunction

    // sin(k*pi/(2*N)) in Q15 from a Q30 taylor series, evaluated at elaboration
    function automatic logic [GAIN_W-1:0] pan_sin(int k);
        longint x;
        longint term;
        longint sum;
        x    = (HALF_PI_Q30 * longint'(k)) >>> PAN_SHIFT;
        term = x;
        sum  = x;
        term = taylor_step(term, x) / 64'sd6;
        sum  = sum - term;
        term = taylor_step(term, x) / 64'sd20;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'sd42;
        sum  = sum - term;
        term = taylor_step(term, x) / 64'sd72;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'sd110;
        sum  = sum - term;
        term = taylor_step(term, x) / 64'sd156;
        sum  = sum + term;
        term = taylor_step(term, x) / 64'sd210;
        sum  = sum - term;
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + (longint'(1) << 14)) >>> 15;
        if (sum > 32768) begin
            sum = 32768;
        end
        return GAIN_W'(sum);
    endfunction

endpackage

// ===== sv/smbpg_mix_if.sv =====
// valid/ready channel carrying one clip contribution
interface smbpg_mix_if;
    import smbpg_pkg::*;

    logic      valid;
    logic      ready;
    t_mix_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/smbpg_frame_if.sv =====
// valid/ready channel carrying one emitted frame
interface smbpg_frame_if;
    import smbpg_pkg::*;

    logic        valid;
    logic        ready;
    t_frame_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stereo_mix_bus_pan_gain.sv =====
// top level of the stereo mix bus with gain, pan, mute/solo and per-frame accumulation
// Takes one clip contribution per clock while i_mix.ready is high and adds it into a
// 1024-slot stereo accumulator in one memory with a read port and a write port; each
// item reads, adds and writes back its slot, with the previous write forwarded so
// back-to-back items on one slot add correctly. The multiply chain (clip, track, fade
// gain, then pan gain) is six register stages; a frame marked last then passes the emit register into
// a 16-entry output queue. Apart from the clear pass, i_mix.ready drops only while 16
// emitted frames are queued or in flight. After reset the accumulator is cleared one
// slot per clock with i_mix.ready low; configuration writes are taken at any time.
module stereo_mix_bus_pan_gain (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smbpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smbpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    smbpg_mix_if.sink                        i_mix,
    smbpg_frame_if.source                    o_frame
);
    import smbpg_pkg::*;

    logic        r_stereo_output;
    logic        r_solo_active;
    logic        w_clr_busy;
    logic        w_room;
    logic        w_accept;
    logic        w_take;
    logic        w_push;
    t_frame_item w_push_item;
    t_rd_req     w_rd_req;
    t_acc_req    w_acc_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo_output <= 1'b1;
            r_solo_active   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STEREO_OUTPUT: r_stereo_output <= i_cfg_wdata[0];
                CFG_SOLO_ACTIVE:   r_solo_active   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign i_mix.ready = ~w_clr_busy & w_room;
    assign w_accept    = i_mix.valid & i_mix.ready;
    assign w_take      = w_accept & (32'(i_mix.data.frame_slot) < 32'(MAX_FRAMES));

    smbpg_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_take),
        .i_item        (i_mix.data),
        .i_solo_active (r_solo_active),
        .o_rd_req      (w_rd_req),
        .o_acc_req     (w_acc_req)
    );

    smbpg_acc u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rd_req        (w_rd_req),
        .i_acc_req       (w_acc_req),
        .i_stereo_output (r_stereo_output),
        .o_clr_busy      (w_clr_busy),
        .o_push          (w_push),
        .o_push_item     (w_push_item)
    );

    smbpg_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_reserve   (w_take & i_mix.data.last_contribution),
        .o_room      (w_room),
        .o_frame     (o_frame)
    );

endmodule

// ===== sv/smbpg_scale.sv =====
// gain and equal-power pan pipeline producing per-item accumulator contributions
module smbpg_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  smbpg_pkg::t_mix_item i_item,
    input  logic                 i_solo_active,
    output smbpg_pkg::t_rd_req   o_rd_req,
    output smbpg_pkg::t_acc_req  o_acc_req
);
    import smbpg_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              skip;
        logic              last;
    } t_ctl;

    localparam int POS_W  = 17;
    localparam int PROD_W = POS_W + IDX_W + 1;
    localparam int IDXF_W = PROD_W - 16;

    logic [GAIN_W-1:0] w_pan_tab [PAN_TABLE_SIZE+1];

    for (genvar g = 0; g <= PAN_TABLE_SIZE; g++) begin : g_pan_tab
        localparam logic [GAIN_W-1:0] SIN_VAL = pan_sin(g);
        assign w_pan_tab[g] = SIN_VAL;
    end

    logic [1:6] r_vld;
    t_ctl       r_ctl [1:6];

    logic signed [32:0]          r1_pl, r1_pr;
    logic        [15:0]          r1_tg;
    logic        [14:0]          r1_fg;
    logic signed [16:0]          r1_pan;
    logic signed [34:0]          r2_pl, r2_pr;
    logic        [14:0]          r2_fg;
    logic        [IDX_W-1:0]     r2_idx;
    logic                        r2_pan_nz;
    logic signed [35:0]          r3_pl, r3_pr;
    logic        [GAIN_W-1:0]    r3_gl, r3_gr;
    logic                        r3_pan_nz;
    logic signed [CONTRIB_W-1:0] r4_al, r4_ar, r4_mono;
    logic        [GAIN_W-1:0]    r4_gl, r4_gr;
    logic                        r4_pan_nz;
    logic signed [38:0]          r5_pl, r5_pr;
    logic signed [CONTRIB_W-1:0] r5_al, r5_ar;
    logic                        r5_pan_nz;
    logic signed [CONTRIB_W-1:0] r6_cl, r6_cr;

    logic                        w_skip;
    logic signed [16:0]          w_pan_sum;
    logic signed [16:0]          w_pan_clamp;
    logic signed [32:0]          w2_rl, w2_rr;
    logic signed [17:0]          w2_al, w2_ar;
    logic        [POS_W-1:0]     w2_pos;
    logic        [PROD_W-1:0]    w2_prod;
    logic        [IDXF_W-1:0]    w2_idx_full;
    logic signed [34:0]          w3_rl, w3_rr;
    logic signed [19:0]          w3_al, w3_ar;
    logic signed [35:0]          w4_rl, w4_rr;
    logic signed [CONTRIB_W-1:0] w4_al, w4_ar;
    logic signed [CONTRIB_W:0]   w4_ms;
    logic signed [38:0]          w6_rl, w6_rr;
    logic signed [CONTRIB_W-1:0] w6_al, w6_ar;

    assign w_skip = i_item.clip_muted | i_item.trk_muted
                  | (i_solo_active & ~i_item.trk_solo);

    assign w_pan_sum = $signed({i_item.clip_pan[15], i_item.clip_pan})
                     + $signed({i_item.trk_pan[15], i_item.trk_pan});

    always_comb begin
        if (w_pan_sum > 17'sd32768) begin
            w_pan_clamp = 17'sd32768;
        end else if (w_pan_sum < -17'sd32768) begin
            w_pan_clamp = -17'sd32768;
        end else begin
            w_pan_clamp = w_pan_sum;
        end
    end

    // round half up then drop 14 fraction bits
    assign w2_rl = r1_pl + 33'sd8192;
    assign w2_rr = r1_pr + 33'sd8192;
    assign w2_al = w2_rl[31:14];
    assign w2_ar = w2_rr[31:14];

    assign w2_pos      = r1_pan + 17'sd32768;
    assign w2_prod     = PROD_W'(w2_pos) * PROD_W'(PAN_TABLE_SIZE) + PROD_W'(32768);
    assign w2_idx_full = w2_prod[PROD_W-1:16];

    assign w3_rl = r2_pl + 35'sd8192;
    assign w3_rr = r2_pr + 35'sd8192;
    assign w3_al = w3_rl[33:14];
    assign w3_ar = w3_rr[33:14];

    assign w4_rl = r3_pl + 36'sd8192;
    assign w4_rr = r3_pr + 36'sd8192;
    assign w4_al = w4_rl[34:14];
    assign w4_ar = w4_rr[34:14];
    assign w4_ms = {w4_al[CONTRIB_W-1], w4_al} + {w4_ar[CONTRIB_W-1], w4_ar}
                 + (CONTRIB_W+1)'(1);

    assign w6_rl = r5_pl + 39'sd16384;
    assign w6_rr = r5_pr + 39'sd16384;
    assign w6_al = w6_rl[35:15];
    assign w6_ar = w6_rr[35:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {i_valid, r_vld[1:5]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[1] <= '{slot: i_item.frame_slot, skip: w_skip,
                      last: i_item.last_contribution};
        for (int s = 2; s <= 6; s++) begin
            r_ctl[s] <= r_ctl[s-1];
        end

        r1_pl  <= $signed(i_item.sample_left) * $signed({1'b0, i_item.clip_gain});
        r1_pr  <= $signed(i_item.sample_right) * $signed({1'b0, i_item.clip_gain});
        r1_tg  <= i_item.track_gain;
        r1_fg  <= i_item.fade_gain;
        r1_pan <= w_pan_clamp;

        r2_pl     <= w2_al * $signed({1'b0, r1_tg});
        r2_pr     <= w2_ar * $signed({1'b0, r1_tg});
        r2_fg     <= r1_fg;
        r2_pan_nz <= (r1_pan != 17'sd0);
        if (w2_idx_full > IDXF_W'(PAN_TABLE_SIZE)) begin
            r2_idx <= IDX_W'(PAN_TABLE_SIZE);
        end else begin
            r2_idx <= w2_idx_full[IDX_W-1:0];
        end

        r3_pl     <= w3_al * $signed({1'b0, r2_fg});
        r3_pr     <= w3_ar * $signed({1'b0, r2_fg});
        r3_gl     <= w_pan_tab[IDX_W'(PAN_TABLE_SIZE) - r2_idx];
        r3_gr     <= w_pan_tab[r2_idx];
        r3_pan_nz <= r2_pan_nz;

        r4_al     <= w4_al;
        r4_ar     <= w4_ar;
        r4_mono   <= w4_ms[CONTRIB_W:1];
        r4_gl     <= r3_gl;
        r4_gr     <= r3_gr;
        r4_pan_nz <= r3_pan_nz;

        r5_pl     <= r4_mono * $signed({1'b0, r4_gl});
        r5_pr     <= r4_mono * $signed({1'b0, r4_gr});
        r5_al     <= r4_al;
        r5_ar     <= r4_ar;
        r5_pan_nz <= r4_pan_nz;

        if (r_ctl[5].skip) begin
            r6_cl <= '0;
            r6_cr <= '0;
        end else if (r5_pan_nz) begin
            r6_cl <= w6_al;
            r6_cr <= w6_ar;
        end else begin
            r6_cl <= r5_al;
            r6_cr <= r5_ar;
        end
    end

    // read one stage ahead so the memory data lines up with the add
    assign o_rd_req.valid = r_vld[5];
    assign o_rd_req.slot  = r_ctl[5].slot;

    assign o_acc_req.valid     = r_vld[6];
    assign o_acc_req.slot      = r_ctl[6].slot;
    assign o_acc_req.last      = r_ctl[6].last;
    assign o_acc_req.contrib_l = r6_cl;
    assign o_acc_req.contrib_r = r6_cr;

endmodule

// ===== sv/smbpg_acc.sv =====
// per-slot accumulator memory with read-modify-write, forwarding, clear pass and frame emit
module smbpg_acc (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  smbpg_pkg::t_rd_req     i_rd_req,
    input  smbpg_pkg::t_acc_req    i_acc_req,
    input  logic                   i_stereo_output,
    output logic                   o_clr_busy,
    output logic                   o_push,
    output smbpg_pkg::t_frame_item o_push_item
);
    import smbpg_pkg::*;

    localparam int SUM_W = ((ACC_BITS > CONTRIB_W) ? ACC_BITS : CONTRIB_W) + 1;
    localparam int EMT_W = ACC_BITS + 1;

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        SUM_W'((longint'(1) <<< (ACC_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_FRAMES - 1);

    function automatic logic signed [ACC_BITS-1:0] acc_sat(logic signed [SUM_W-1:0] v);
        if (v > ACC_MAX) begin
            return ACC_MAX[ACC_BITS-1:0];
        end else if (v < ACC_MIN) begin
            return ACC_MIN[ACC_BITS-1:0];
        end
        return v[ACC_BITS-1:0];
    endfunction

    // returns {clamped, value}
    function automatic logic [16:0] sat16(logic signed [EMT_W-1:0] v);
        if (v > EMT_W'(32767)) begin
            return {1'b1, 16'h7fff};
        end else if (v < -EMT_W'(32768)) begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, v[15:0]};
    endfunction

    t_acc_pair r_mem [MAX_FRAMES];
    t_acc_pair r_rd_data;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_fwd_vld;
    logic [SLOT_W-1:0] r_fwd_slot;
    t_acc_pair         r_fwd_data;

    logic              r_em_vld;
    logic [SLOT_W-1:0] r_em_slot;
    t_acc_pair         r_em_acc;

    t_acc_pair               w_old;
    t_acc_pair               w_new;
    logic signed [SUM_W-1:0] w_sum_l, w_sum_r;
    logic                    w_wr_en;
    logic [ADDR_W-1:0]       w_wr_addr;
    t_acc_pair               w_wr_data;
    logic signed [EMT_W-1:0] w_em_l, w_em_r, w_em_ms, w_em_mono;
    logic [16:0]             w_sat_l, w_sat_r, w_sat_m;

    assign w_old = (r_fwd_vld && r_fwd_slot == i_acc_req.slot) ? r_fwd_data : r_rd_data;

    assign w_sum_l = SUM_W'(w_old.left) + SUM_W'(i_acc_req.contrib_l);
    assign w_sum_r = SUM_W'(w_old.right) + SUM_W'(i_acc_req.contrib_r);
    assign w_new.left  = acc_sat(w_sum_l);
    assign w_new.right = acc_sat(w_sum_r);

    always_comb begin
        if (r_clr_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = i_acc_req.valid;
            w_wr_addr = ADDR_W'(i_acc_req.slot);
            w_wr_data = i_acc_req.last ? t_acc_pair'('0) : w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_req.valid) begin
            r_rd_data <= r_mem[ADDR_W'(i_rd_req.slot)];
        end
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_fwd_vld  <= 1'b0;
            r_em_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                end
            end
            r_fwd_vld <= i_acc_req.valid;
            r_em_vld  <= i_acc_req.valid & i_acc_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_slot <= i_acc_req.slot;
        r_fwd_data <= w_wr_data;
        r_em_slot  <= i_acc_req.slot;
        r_em_acc   <= w_new;
    end

    assign w_em_l    = EMT_W'(r_em_acc.left);
    assign w_em_r    = EMT_W'(r_em_acc.right);
    assign w_em_ms   = w_em_l + w_em_r + EMT_W'(1);
    assign w_em_mono = w_em_ms >>> 1;

    assign w_sat_l = sat16(w_em_l);
    assign w_sat_r = sat16(w_em_r);
    assign w_sat_m = sat16(w_em_mono);

    always_comb begin
        o_push_item.out_slot = r_em_slot;
        if (i_stereo_output) begin
            o_push_item.out_left  = w_sat_l[15:0];
            o_push_item.out_right = w_sat_r[15:0];
            o_push_item.saturated = w_sat_l[16] | w_sat_r[16];
        end else begin
            o_push_item.out_left  = w_sat_m[15:0];
            o_push_item.out_right = w_sat_m[15:0];
            o_push_item.saturated = w_sat_m[16];
        end
    end

    assign o_push     = r_em_vld;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== sv/smbpg_fifo.sv =====
// output frame queue with credit count covering frames still in the pipeline
module smbpg_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  smbpg_pkg::t_frame_item i_push_item,
    input  logic                   i_reserve,
    output logic                   o_room,
    smbpg_frame_if.source          o_frame
);
    import smbpg_pkg::*;

    t_frame_item r_buf [FIFO_DEPTH];

    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_fill;
    logic [FIFO_CW-1:0] r_credit;
    logic               w_pop;

    assign o_frame.valid = (r_fill != '0);
    assign o_frame.data  = r_buf[r_rd_ptr];
    assign w_pop         = o_frame.valid & o_frame.ready;
    assign o_room        = (r_credit < FIFO_CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill   <= r_fill + FIFO_CW'(i_push) - FIFO_CW'(w_pop);
            r_credit <= r_credit + FIFO_CW'(i_reserve) - FIFO_CW'(w_pop);
        end
    end

endmodule

// ===== sv/smbpg_chk.sv =====
// port-level assertions for the stereo mix bus, bound to the top level
module smbpg_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_mix_ready,
    input logic                   i_frame_valid,
    input logic                   i_frame_ready,
    input smbpg_pkg::t_frame_item i_frame_item
);
    import smbpg_pkg::*;

    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_valid && !i_frame_ready |=> i_frame_valid)
        else $error("frame dropped while stalled");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_mix_ready)
        else $error("input ready during accumulator clear");

    a_no_frame_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_frame_valid)
        else $error("frame shown right after reset");

    a_sat_means_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_valid && i_frame_item.saturated |->
            (i_frame_item.out_left == 16'sh7fff) || (i_frame_item.out_left == -16'sh8000)
            || (i_frame_item.out_right == 16'sh7fff)
            || (i_frame_item.out_right == -16'sh8000))
        else $error("saturated flag without a clamped channel");

endmodule

bind stereo_mix_bus_pan_gain smbpg_chk u_smbpg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_mix_ready   (i_mix.ready),
    .i_frame_valid (o_frame.valid),
    .i_frame_ready (o_frame.ready),
    .i_frame_item  (o_frame.data)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the stereo mix bus: random and directed contributions, frame scoreboard
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smbpg_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 800;
    localparam int PHASE_ITEMS   = 460;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    smbpg_mix_if   mix_ch();
    smbpg_frame_if frame_ch();

    stereo_mix_bus_pan_gain uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_mix       (mix_ch),
        .o_frame     (frame_ch)
    );

    // mixer model state
    longint acc_l [MAX_FRAMES];
    longint acc_r [MAX_FRAMES];
    int     sine_q15 [PAN_TABLE_SIZE + 1];
    bit     stereo_on;
    bit     solo_on;

    t_mix_item   mix_backlog [$];
    t_frame_item frames_due  [$];

    int errors      = 0;
    int frames_seen = 0;
    int cycles      = 0;
    int tx_gap      = 0;
    int tx_quiet    = 0;
    int rx_gap      = 0;
    int rx_quiet    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int quarter_sine(int k);
        longint angle;
        longint term;
        longint sum;
        angle = (64'sd1686629713 * longint'(k)) / PAN_TABLE_SIZE;
        term  = angle;
        sum   = angle;
        for (int j = 1; j <= 7; j++) begin
            term = (term * angle) >>> 30;
            term = (term * angle) >>> 30;
            term = term / longint'((2 * j) * (2 * j + 1));
            if ((j % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 32768) begin
            sum = 32768;
        end
        return int'(sum);
    endfunction

    // divide by 2^n, rounding half toward plus infinity
    function automatic longint round_shr(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat_acc(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
        lo = -(longint'(1) <<< (ACC_BITS - 1));
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint clamp_q15(longint v, inout bit hit);
        if (v > 32767) begin
            hit = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            hit = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    task automatic accumulate_contribution(input t_mix_item it);
        longint l, r, cg, tg, fg, pan, mono, idx, ol, orr;
        bit skip;
        bit hit;
        int s;
        t_frame_item fr;
        s    = it.frame_slot;
        hit  = 1'b0;
        skip = it.clip_muted || it.trk_muted || (solo_on && !it.trk_solo);
        if (!skip) begin
            cg  = it.clip_gain;
            tg  = it.track_gain;
            fg  = it.fade_gain;
            l   = longint'($signed(it.sample_left));
            r   = longint'($signed(it.sample_right));
            l   = round_shr(round_shr(round_shr(l * cg, 14) * tg, 14) * fg, 14);
            r   = round_shr(round_shr(round_shr(r * cg, 14) * tg, 14) * fg, 14);
            pan = longint'($signed(it.clip_pan)) + longint'($signed(it.trk_pan));
            if (pan > 32768) begin
                pan = 32768;
            end
            if (pan < -32768) begin
                pan = -32768;
            end
            if (pan != 0) begin
                idx = ((pan + 32768) * PAN_TABLE_SIZE + 32768) >>> 16;
                if (idx > PAN_TABLE_SIZE) begin
                    idx = PAN_TABLE_SIZE;
                end
                mono = round_shr(l + r, 1);
                l    = round_shr(mono * sine_q15[PAN_TABLE_SIZE - idx], 15);
                r    = round_shr(mono * sine_q15[idx], 15);
            end
            acc_l[s] = sat_acc(acc_l[s] + l);
            acc_r[s] = sat_acc(acc_r[s] + r);
        end
        if (it.last_contribution) begin
            if (stereo_on) begin
                ol  = clamp_q15(acc_l[s], hit);
                orr = clamp_q15(acc_r[s], hit);
            end else begin
                ol  = clamp_q15(round_shr(acc_l[s] + acc_r[s], 1), hit);
                orr = ol;
            end
            acc_l[s]     = 0;
            acc_r[s]     = 0;
            fr.out_slot  = it.frame_slot;
            fr.out_left  = ol[15:0];
            fr.out_right = orr[15:0];
            fr.saturated = hit;
            frames_due.push_back(fr);
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_gain(int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 16'd0;
        end
        if (r < 18) begin
            return 16'(top);
        end
        if (r < 30) begin
            return 16'($urandom_range(0, 65535));
        end
        if (r < 42) begin
            return 16'd16384;
        end
        return 16'($urandom_range(0, top));
    endfunction

    function automatic logic [15:0] pick_pan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return 16'h0000;
        end
        if (r < 45) begin
            return 16'h8000;
        end
        if (r < 55) begin
            return 16'h7fff;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_mix_item random_contrib(int slot, bit last);
        t_mix_item it;
        logic [15:0] fg;
        it.frame_slot        = SLOT_W'(slot);
        it.sample_left       = 16'($urandom_range(0, 65535));
        it.sample_right      = 16'($urandom_range(0, 65535));
        it.clip_gain         = pick_gain(65535);
        it.track_gain        = pick_gain(32768);
        fg                   = pick_gain(16384);
        it.fade_gain         = fg[14:0];
        it.clip_pan          = pick_pan();
        it.trk_pan           = pick_pan();
        it.clip_muted        = ($urandom_range(0, 9) == 0);
        it.trk_muted         = ($urandom_range(0, 9) == 0);
        it.trk_solo          = 1'($urandom_range(0, 1));
        it.last_contribution = last;
        return it;
    endfunction

    function automatic t_mix_item plain_item(int slot, int sl, int sr, bit last);
        t_mix_item it;
        it                   = '0;
        it.frame_slot        = SLOT_W'(slot);
        it.sample_left       = 16'(sl);
        it.sample_right      = 16'(sr);
        it.clip_gain         = 16'd16384;
        it.track_gain        = 16'd16384;
        it.fade_gain         = 15'd16384;
        it.last_contribution = last;
        return it;
    endfunction

    // runs of contributions to one slot ending in a last, plus some loose items
    task automatic queue_random(int n);
        t_mix_item it;
        int made;
        int slot;
        int len;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 6) == 0) begin
                it = random_contrib($urandom_range(0, MAX_FRAMES - 1),
                                    1'($urandom_range(0, 1)));
                mix_backlog.push_back(it);
                made++;
            end else begin
                slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(0, MAX_FRAMES - 1);
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    it = random_contrib(slot, k == len - 1);
                    mix_backlog.push_back(it);
                    made++;
                end
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, bit val);
        @(posedge i_clk);
        i_cfg_we  <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        case (idx)
            CFG_STEREO_OUTPUT: stereo_on = val;
            CFG_SOLO_ACTIVE:   solo_on = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (mix_backlog.size() != 0 || mix_ch.valid || frames_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // driver: one transaction per handshake, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mix_ch.valid <= 1'b0;
        end else begin
            if (mix_ch.valid && mix_ch.ready) begin
                accumulate_contribution(mix_ch.data);
            end
            if (!mix_ch.valid || mix_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    mix_ch.valid <= 1'b0;
                end else if (mix_backlog.size() > 0) begin
                    mix_ch.data  <= mix_backlog.pop_front();
                    mix_ch.valid <= 1'b1;
                    if (tx_quiet > 0) begin
                        tx_quiet--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        tx_quiet = $urandom_range(50, 200);
                    end else begin
                        tx_gap = pick_gap();
                    end
                end else begin
                    mix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each frame transaction, then decide ready for the next cycle
    always @(posedge i_clk) begin : frame_check
        t_frame_item want;
        t_frame_item got;
        if (!i_rst_n) begin
            frame_ch.ready <= 1'b0;
        end else begin
            if (frame_ch.valid && frame_ch.ready) begin
                got = frame_ch.data;
                frames_seen++;
                if (frames_due.size() == 0) begin
                    $error("unexpected frame for slot %0d", got.out_slot);
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.out_slot !== want.out_slot) begin
                        $error("out_slot expected %0d got %0d", want.out_slot, got.out_slot);
                        errors++;
                    end
                    if (got.out_left !== want.out_left) begin
                        $error("out_left expected %0d got %0d",
                               $signed(want.out_left), $signed(got.out_left));
                        errors++;
                    end
                    if (got.out_right !== want.out_right) begin
                        $error("out_right expected %0d got %0d",
                               $signed(want.out_right), $signed(got.out_right));
                        errors++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated expected %0d got %0d", want.saturated, got.saturated);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_ch.ready <= 1'b0;
            end else if (!hold_done && frames_seen >= HOLD_AT) begin
                // long back-pressure so the output queue fills and input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                frame_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                frame_ch.ready <= 1'b0;
            end else begin
                frame_ch.ready <= 1'b1;
                if (rx_quiet > 0) begin
                    rx_quiet--;
                end else if ($urandom_range(0, 49) == 0) begin
                    rx_quiet = $urandom_range(50, 200);
                end else begin
                    rx_gap = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        t_mix_item it;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        mix_ch.valid   = 1'b0;
        mix_ch.data    = '0;
        frame_ch.ready = 1'b0;
        stereo_on      = 1'b1;
        solo_on        = 1'b0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            acc_l[k] = 0;
            acc_r[k] = 0;
        end
        for (int k = 0; k <= PAN_TABLE_SIZE; k++) begin
            sine_q15[k] = quarter_sine(k);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: passthrough and sample extremes at both ends of the slot range
        mix_backlog.push_back(plain_item(0, 1000, -2000, 1'b1));
        mix_backlog.push_back(plain_item(MAX_FRAMES - 1, 32767, -32768, 1'b1));
        // full scale sum saturates
        mix_backlog.push_back(plain_item(2, 32767, 32767, 1'b0));
        mix_backlog.push_back(plain_item(2, 32767, 32767, 1'b1));
        it = plain_item(3, 32767, -32768, 1'b1);
        it.clip_gain = 16'hffff;
        it.track_gain = 16'd32768;
        mix_backlog.push_back(it);
        // pan: hard left, clamped hard right, clamped hard left, cancel, near center
        it = plain_item(4, 12000, 8000, 1'b1);
        it.clip_pan = 16'h8000;
        mix_backlog.push_back(it);
        it.frame_slot = 5;
        it.clip_pan = 16'h7fff;
        it.trk_pan = 16'h7fff;
        mix_backlog.push_back(it);
        it.frame_slot = 6;
        it.clip_pan = 16'h8000;
        it.trk_pan = 16'h8000;
        mix_backlog.push_back(it);
        it.frame_slot = 7;
        it.clip_pan = 16'sd1000;
        it.trk_pan = -16'sd1000;
        mix_backlog.push_back(it);
        it.frame_slot = 8;
        it.clip_pan = 16'sd1;
        it.trk_pan = 16'sd0;
        mix_backlog.push_back(it);
        // skipped contributions still emit the slot
        mix_backlog.push_back(plain_item(9, 5000, -5000, 1'b0));
        it = plain_item(9, 5000, -5000, 1'b1);
        it.clip_muted = 1'b1;
        mix_backlog.push_back(it);
        mix_backlog.push_back(plain_item(10, 7000, 3000, 1'b0));
        it = plain_item(10, 7000, 3000, 1'b1);
        it.trk_muted = 1'b1;
        mix_backlog.push_back(it);
        // gains above the stated range, then a silent frame
        it = plain_item(11, -12345, 23456, 1'b1);
        it.track_gain = 16'hffff;
        it.fade_gain = 15'h7fff;
        mix_backlog.push_back(it);
        it = plain_item(12, 32767, -32768, 1'b1);
        it.clip_gain = 16'd0;
        mix_backlog.push_back(it);
        // accumulator overflow on both channels
        for (int k = 0; k < 9; k++) begin
            it = plain_item(13, 32767, -32768, k == 8);
            it.clip_gain = 16'hffff;
            it.track_gain = 16'hffff;
            it.fade_gain = 15'h7fff;
            mix_backlog.push_back(it);
        end
        drain();

        write_reg(CFG_STEREO_OUTPUT, 1'b0);
        write_reg(CFG_SOLO_ACTIVE, 1'b0);
        queue_random(PHASE_ITEMS);
        drain();

        write_reg(CFG_SOLO_ACTIVE, 1'b1);
        queue_random(PHASE_ITEMS);
        drain();

        write_reg(CFG_STEREO_OUTPUT, 1'b1);
        queue_random(PHASE_ITEMS);
        drain();

        write_reg(CFG_SOLO_ACTIVE, 1'b0);
        queue_random(PHASE_ITEMS);
        drain();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
